// ===== hw/rtl/bfhs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the back/forward history stacks.
// No dependencies; imported by bfhs_stack, back_forward_history_stacks and tb_top.
package bfhs_pkg;

    // Default sizes
    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int PAGE_BITS_DEF     = 32;

    // Fixed beat field widths
    localparam int OPCODE_W  = 2;
    localparam int PAGE_ID_W = 32;
    localparam int DEPTH_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;

    // Navigation commands
    typedef enum logic [OPCODE_W-1:0] {
        OP_VISIT   = 2'd0,
        OP_BACK    = 2'd1,
        OP_FORWARD = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE       = 2'd0,
        STAT_NO_BACK    = 2'd1,
        STAT_NO_FORWARD = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Per-stack control for one command
    typedef struct packed {
        logic rd_en;   // fetch top entry into read register
        logic push;    // write page at count, grow if not full
        logic pop;     // shrink by one if not empty
        logic clear;   // drop all entries
    } stack_ctl_t;

endpackage

// ===== hw/rtl/bfhs_stack.sv =====
`timescale 1ns / 1ps
// Bounded page stack: one synchronous memory plus a fill count.
// Depends on bfhs_pkg for the control struct.
module bfhs_stack
    import bfhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PAGE_BITS     = PAGE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  stack_ctl_t                             ctl,
    input  logic [PAGE_BITS-1:0]                   push_data,
    output logic [PAGE_BITS-1:0]                   rd_data,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]     count_next,
    output logic                                   empty
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [PAGE_BITS-1:0] mem [HISTORY_DEPTH];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [CW-1:0]        count_reg;
    logic                 full;
    logic [AW-1:0]        top_addr;
    logic [AW-1:0]        wr_addr;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(HISTORY_DEPTH));
    assign top_addr = AW'(count_reg - CW'(1));
    assign wr_addr  = count_reg[AW-1:0];

    // Fill count update
    always_comb begin
        count_next = count_reg;
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop && !empty) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Memory: write on push, registered read of the top entry
    always_ff @(posedge aclk) begin
        if (ctl.push && !full) begin
            mem[wr_addr] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[top_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/back_forward_history_stacks.sv =====
`timescale 1ns / 1ps
// Back/forward navigation history: current page register and two stacks.
// Depends on bfhs_pkg and bfhs_stack.
//
// Usage:
//   Slave stream s_* carries one command per beat: opcode (visit, back,
//   forward) and the page identifier used by visit. Master stream m_*
//   returns one result beat per command: current page, both stack depths
//   and a status (done, nothing to go back to, nothing to go forward to).
//   The sequencer accepts a command in its idle state, where the top of
//   both stacks is read from memory; in its execute state it writes back
//   the push and loads the result register. No new command is accepted
//   until the previous one has executed.
//   A new command is taken while the previous result still waits in the
//   output register; if the receiver stalls, the second command holds in
//   its execute state until the output register frees up.
//   Reset clears both stack counts and sets the current page to the
//   opening page (identifier 0); stack memories are not cleared.
module back_forward_history_stacks
    import bfhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PAGE_BITS     = PAGE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // opcode[1:0], page_id[33:2], zero[39:34]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // current_page[31:0], back_depth[37:32],
                                           // forward_depth[43:38], status[45:44],
                                           // zero[47:46]
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] cur_reg, cur_next;
    status_t              status_next;
    logic                 exec_go;
    logic                 s_fire;

    stack_ctl_t           back_ctl, fwd_ctl;
    logic [PAGE_BITS-1:0] back_rd, fwd_rd;
    logic [CW-1:0]        back_cnt_next;
    logic [CW-1:0]        fwd_cnt_next;
    logic                 back_empty, fwd_empty;

    logic                 m_tvalid_reg;
    logic [PAGE_ID_W-1:0] m_page_reg;
    logic [DEPTH_W-1:0]   m_back_reg, m_fwd_reg;
    status_t              m_status_reg;

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EXEC: exec_go  = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= op_t'(s_tdata[OPCODE_W-1:0]);
            page_reg <= PAGE_BITS'(s_tdata[OPCODE_W +: PAGE_ID_W]);
        end
    end

    // Command decode into stack controls and new current page
    always_comb begin
        back_ctl       = '0;
        fwd_ctl        = '0;
        back_ctl.rd_en = s_fire;
        fwd_ctl.rd_en  = s_fire;
        cur_next       = cur_reg;
        status_next    = STAT_DONE;
        case (op_reg)
            OP_VISIT: begin
                back_ctl.push = exec_go;
                fwd_ctl.clear = exec_go;
                cur_next      = page_reg;
            end
            OP_BACK: begin
                if (back_empty) begin
                    status_next = STAT_NO_BACK;
                end else begin
                    fwd_ctl.push = exec_go;
                    back_ctl.pop = exec_go;
                    cur_next     = back_rd;
                end
            end
            OP_FORWARD: begin
                if (fwd_empty) begin
                    status_next = STAT_NO_FORWARD;
                end else begin
                    back_ctl.push = exec_go;
                    fwd_ctl.pop   = exec_go;
                    cur_next      = fwd_rd;
                end
            end
            default: ;
        endcase
    end

    // Current page
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (exec_go) begin
            cur_reg <= cur_next;
        end
    end

    bfhs_stack #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_BITS     (PAGE_BITS)
    ) u_back_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (back_ctl),
        .push_data  (cur_reg),
        .rd_data    (back_rd),
        .count_next (back_cnt_next),
        .empty      (back_empty)
    );

    bfhs_stack #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_BITS     (PAGE_BITS)
    ) u_fwd_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (fwd_ctl),
        .push_data  (cur_reg),
        .rd_data    (fwd_rd),
        .count_next (fwd_cnt_next),
        .empty      (fwd_empty)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            m_page_reg   <= PAGE_ID_W'(cur_next);
            m_back_reg   <= DEPTH_W'(back_cnt_next);
            m_fwd_reg    <= DEPTH_W'(fwd_cnt_next);
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_fwd_reg, m_back_reg, m_page_reg};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for back_forward_history_stacks: drives navigation commands
// on the s_ stream and checks every result beat against a behavioral history model.
// Depends on bfhs_pkg and the back_forward_history_stacks RTL.
module tb_top
    import bfhs_pkg::*;
();

    localparam int DEPTH       = HISTORY_DEPTH_DEF;
    localparam int N_RANDOM    = 1450;
    localparam int CALM_LEFT   = 150;   // no idling once this few commands remain
    localparam int HOLD_AFTER  = 400;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 10;

    // Opcode with no command behind it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Expected result beat
    typedef struct packed {
        logic [PAGE_ID_W-1:0] page;
        logic [DEPTH_W-1:0]   back_depth;
        logic [DEPTH_W-1:0]   fwd_depth;
        logic [STATUS_W-1:0]  status;
    } nav_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    back_forward_history_stacks uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Commands waiting to be sent, results waiting to arrive
    logic [S_DATA_W-1:0] cmd_q[$];
    nav_result_t         result_q[$];
    logic                calm = 1'b0;
    int                  n_accepted = 0;
    int                  n_checked  = 0;
    int                  n_errors   = 0;

    // History model state
    logic [PAGE_ID_W-1:0] cur_page = '0;
    logic [PAGE_ID_W-1:0] back_pages [DEPTH];
    logic [PAGE_ID_W-1:0] fwd_pages  [DEPTH];
    int                   back_cnt = 0;
    int                   fwd_cnt  = 0;
    int                   n_visit = 0, n_back = 0, n_fwd = 0, n_unused = 0;
    int                   n_no_back = 0, n_no_fwd = 0, n_full_drop = 0;

    function automatic logic [S_DATA_W-1:0] pack_cmd(logic [OPCODE_W-1:0] op,
                                                     logic [PAGE_ID_W-1:0] page);
        return {{(S_DATA_W - OPCODE_W - PAGE_ID_W){1'b0}}, page, op};
    endfunction

    function automatic logic [PAGE_ID_W-1:0] rand_page();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Advance the history by one command and queue the result it must produce
    task automatic apply_nav(input logic [S_DATA_W-1:0] cmd);
        logic [OPCODE_W-1:0]  op;
        logic [PAGE_ID_W-1:0] page;
        status_t              st;
        nav_result_t          r;
        op   = cmd[OPCODE_W-1:0];
        page = cmd[OPCODE_W +: PAGE_ID_W];
        st   = STAT_DONE;
        case (op)
            OP_VISIT: begin
                n_visit++;
                if (back_cnt < DEPTH) begin
                    back_pages[back_cnt] = cur_page;
                    back_cnt++;
                end else begin
                    n_full_drop++;
                end
                cur_page = page;
                fwd_cnt  = 0;
            end
            OP_BACK: begin
                n_back++;
                if (back_cnt == 0) begin
                    st = STAT_NO_BACK;
                    n_no_back++;
                end else begin
                    if (fwd_cnt < DEPTH) begin
                        fwd_pages[fwd_cnt] = cur_page;
                        fwd_cnt++;
                    end else begin
                        n_full_drop++;
                    end
                    back_cnt--;
                    cur_page = back_pages[back_cnt];
                end
            end
            OP_FORWARD: begin
                n_fwd++;
                if (fwd_cnt == 0) begin
                    st = STAT_NO_FORWARD;
                    n_no_fwd++;
                end else begin
                    if (back_cnt < DEPTH) begin
                        back_pages[back_cnt] = cur_page;
                        back_cnt++;
                    end else begin
                        n_full_drop++;
                    end
                    fwd_cnt--;
                    cur_page = fwd_pages[fwd_cnt];
                end
            end
            default: begin
                // unused code: history untouched
                n_unused++;
            end
        endcase
        r.page       = cur_page;
        r.back_depth = back_cnt[DEPTH_W-1:0];
        r.fwd_depth  = fwd_cnt[DEPTH_W-1:0];
        r.status     = st;
        result_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, n_checked, what, got, want);
        n_errors++;
    endtask

    // Driver: one command beat at a time, random idle bursts between beats
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && s_tready) begin
                apply_nav(s_tdata);
                n_accepted++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                s_tdata  <= cmd_q.pop_front();
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 19);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        calm <= (cmd_q.size() < CALM_LEFT);
    end

    // Monitor: check result beats, random stalls and one long hold-off
    int  stall_cnt = 0;
    int  hold_cnt  = 0;
    bit  hold_done = 0;
    always @(posedge aclk) begin
        nav_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $display("[%0t] result beat 0x%0h with no command outstanding",
                             $realtime, m_tdata);
                    n_errors++;
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[31:0] !== want.page)
                        report_mismatch("current_page", 64'(m_tdata[31:0]),
                                        64'(want.page));
                    if (m_tdata[37:32] !== want.back_depth)
                        report_mismatch("back_depth", 64'(m_tdata[37:32]),
                                        64'(want.back_depth));
                    if (m_tdata[43:38] !== want.fwd_depth)
                        report_mismatch("forward_depth", 64'(m_tdata[43:38]),
                                        64'(want.fwd_depth));
                    if (m_tdata[45:44] !== want.status)
                        report_mismatch("status", 64'(m_tdata[45:44]),
                                        64'(want.status));
                end
                n_checked++;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1;
                hold_cnt  = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_cnt = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int n_total;
        int len;
        int kind;
        int op;
        // directed: empty stacks, unused code, extreme pages, forward clearing
        cmd_q.push_back(pack_cmd(OP_BACK, '1));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '1));
        cmd_q.push_back(pack_cmd(OP_UNUSED, 32'hDEAD_BEEF));
        cmd_q.push_back(pack_cmd(OP_VISIT, '1));
        cmd_q.push_back(pack_cmd(OP_VISIT, '0));
        cmd_q.push_back(pack_cmd(OP_VISIT, 32'hAAAA_AAAA));
        cmd_q.push_back(pack_cmd(OP_VISIT, 32'h5555_5555));
        cmd_q.push_back(pack_cmd(OP_BACK, '0));
        cmd_q.push_back(pack_cmd(OP_BACK, '0));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '0));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '0));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '0));
        cmd_q.push_back(pack_cmd(OP_BACK, '0));
        cmd_q.push_back(pack_cmd(OP_BACK, '0));
        cmd_q.push_back(pack_cmd(OP_VISIT, 32'h1234_5678));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '0));
        cmd_q.push_back(pack_cmd(OP_UNUSED, '1));
        for (int i = 0; i < 5; i++)
            cmd_q.push_back(pack_cmd(OP_BACK, '0));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '1));
        cmd_q.push_back(pack_cmd(OP_FORWARD, '1));

        // random: runs of visits to fill, backs to unwind, forwards to replay, mixes
        n_total = cmd_q.size() + N_RANDOM;
        while (cmd_q.size() < n_total) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                len = $urandom_range(20, 40);
                for (int i = 0; i < len; i++)
                    cmd_q.push_back(pack_cmd(OP_VISIT, rand_page()));
            end else if (kind <= 4) begin
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++)
                    cmd_q.push_back(pack_cmd(OP_BACK, rand_page()));
            end else if (kind <= 6) begin
                len = $urandom_range(5, 35);
                for (int i = 0; i < len; i++)
                    cmd_q.push_back(pack_cmd(OP_FORWARD, rand_page()));
            end else if (kind <= 8) begin
                len = $urandom_range(5, 30);
                for (int i = 0; i < len; i++) begin
                    op = $urandom_range(0, 9);
                    if (op <= 2)
                        cmd_q.push_back(pack_cmd(OP_VISIT, rand_page()));
                    else if (op <= 6)
                        cmd_q.push_back(pack_cmd(OP_BACK, rand_page()));
                    else
                        cmd_q.push_back(pack_cmd(OP_FORWARD, rand_page()));
                end
            end else begin
                // noise, unused code included
                len = $urandom_range(3, 10);
                for (int i = 0; i < len; i++)
                    cmd_q.push_back(pack_cmd(OPCODE_W'($urandom_range(0, 3)),
                                             rand_page()));
            end
        end
        n_total = cmd_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(n_accepted == n_total && result_q.size() == 0))
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Ran %0d commands (%0d visit, %0d back, ", n_accepted, n_visit, n_back,
                 "%0d forward, %0d unused code), %0d results checked.",
                 n_fwd, n_unused, n_checked);
        $display("Refused on empty stack: %0d back, %0d forward; ", n_no_back, n_no_fwd,
                 "pages dropped on full stack: %0d.", n_full_drop);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout: %0d results still outstanding", result_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bfhs_pkg.sv
hw/rtl/bfhs_stack.sv
hw/rtl/back_forward_history_stacks.sv
tb/tb_top.sv
